>>> rtl/core/lrbs_pkg.sv
// Shared types, codes and reset constants for the latching relay bypass sequencer.
package lrbs_pkg;

	// Request codes carried by an input item.
	localparam logic [1:0] FUNC_SERVICE = 2'd0;
	localparam logic [1:0] FUNC_PRESS   = 2'd1;
	localparam logic [1:0] FUNC_MIDI    = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] REG_MOMENT_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_US    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_DELAY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLEANUP_DELAY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIDI_DELAY    = 3'd5;

	// Register reset values.
	localparam logic [CFG_DATA_W-1:0] RST_LOCKOUT_US    = 20'd25000;
	localparam logic [CFG_DATA_W-1:0] RST_FLIP_DELAY    = 20'd25000;
	localparam logic [CFG_DATA_W-1:0] RST_CLEANUP_DELAY = 20'd8000;
	localparam logic [CFG_DATA_W-1:0] RST_RELEASE_DELAY = 20'd5000;
	localparam logic [CFG_DATA_W-1:0] RST_MIDI_DELAY    = 20'd20000;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now_us;
	} lrbs_in_t;

	typedef struct packed {
		logic isolator_level;
		logic lock_level;
		logic switch_level;
		logic bypass_led;
		logic relay_on;
	} lrbs_out_t;

	typedef struct packed {
		logic                  moment_mode;
		logic [CFG_DATA_W-1:0] lockout_us;
		logic [CFG_DATA_W-1:0] flip_delay_us;
		logic [CFG_DATA_W-1:0] cleanup_delay_us;
		logic [CFG_DATA_W-1:0] release_delay_us;
		logic [CFG_DATA_W-1:0] midi_delay_us;
	} lrbs_cfg_t;

	// A deadline is reached when now - at, read as two's complement, is not negative.
	function automatic logic reached(input logic [31:0] now, input logic [31:0] at);
		logic [31:0] diff;
		diff = now - at;
		return ~diff[31];
	endfunction

endpackage

>>> rtl/core/lrbs_cfg_regs.sv
// Configuration register bank of the relay bypass sequencer.
module lrbs_cfg_regs
	import lrbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output lrbs_cfg_t             cfg
);

	lrbs_cfg_t cfg_q;

	// Register writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.moment_mode      <= 1'b0;
			cfg_q.lockout_us       <= RST_LOCKOUT_US;
			cfg_q.flip_delay_us    <= RST_FLIP_DELAY;
			cfg_q.cleanup_delay_us <= RST_CLEANUP_DELAY;
			cfg_q.release_delay_us <= RST_RELEASE_DELAY;
			cfg_q.midi_delay_us    <= RST_MIDI_DELAY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MOMENT_MODE:   cfg_q.moment_mode      <= cfg_data[0];
				REG_LOCKOUT_US:    cfg_q.lockout_us       <= cfg_data;
				REG_FLIP_DELAY:    cfg_q.flip_delay_us    <= cfg_data;
				REG_CLEANUP_DELAY: cfg_q.cleanup_delay_us <= cfg_data;
				REG_RELEASE_DELAY: cfg_q.release_delay_us <= cfg_data;
				REG_MIDI_DELAY:    cfg_q.midi_delay_us    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/lrbs_step.sv
// Sequencer state and the single-pass update logic for one item.
module lrbs_step
	import lrbs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  lrbs_in_t  item,
	input  lrbs_cfg_t cfg,
	output lrbs_out_t result
);

	logic        engaged_q, flip_pend_q, cln_pend_q, rel_pend_q, midi_pend_q;
	logic        iso_q, lock_q, switch_q;
	logic [31:0] last_press_q, flip_dl_q, cln_dl_q, rel_dl_q, midi_dl_q;

	logic        engaged_d, flip_pend_d, cln_pend_d, rel_pend_d, midi_pend_d;
	logic        iso_d, lock_d, switch_d;
	logic [31:0] last_press_d, flip_dl_d, cln_dl_d, rel_dl_d, midi_dl_d;

	logic        svc, prs, arm;
	logic        flip_fire, cln_fire, rel_fire, midi_fire, do_press, press_start;
	logic [31:0] now, press_gap;

	// Decide which deadlines fire. A stage armed in this same item fires at
	// once only when its delay is zero, since the new deadline is now + delay.
	always_comb begin
		now       = item.now_us;
		svc       = (item.func == FUNC_SERVICE);
		prs       = (item.func == FUNC_PRESS);
		arm       = (item.func == FUNC_MIDI);
		flip_fire = svc && flip_pend_q && reached(now, flip_dl_q);
		if (flip_fire) begin
			cln_fire = svc && (cfg.cleanup_delay_us == '0);
		end else begin
			cln_fire = svc && cln_pend_q && reached(now, cln_dl_q);
		end
		if (cln_fire) begin
			rel_fire = svc && (cfg.release_delay_us == '0);
		end else begin
			rel_fire = svc && rel_pend_q && reached(now, rel_dl_q);
		end
		midi_fire   = svc && midi_pend_q && reached(now, midi_dl_q);
		do_press    = prs || (midi_fire && !cfg.moment_mode);
		press_gap   = now - last_press_q;
		press_start = do_press && (press_gap > {12'b0, cfg.lockout_us});
	end

	// Next state in service order: flip, cleanup, release, then the press.
	always_comb begin
		engaged_d = engaged_q ^ flip_fire;

		lock_d   = lock_q;
		switch_d = switch_q;
		if (flip_fire) begin
			lock_d   = !engaged_d;
			switch_d = engaged_d;
		end
		if (cln_fire) begin
			lock_d   = 1'b0;
			switch_d = 1'b0;
		end

		iso_d = iso_q;
		if (rel_fire) begin
			iso_d = 1'b1;
		end
		if (press_start) begin
			iso_d = 1'b0;
		end

		flip_pend_d = (flip_pend_q && !flip_fire) || press_start;
		flip_dl_d   = press_start ? now + {12'b0, cfg.flip_delay_us} : flip_dl_q;

		cln_pend_d = (cln_pend_q || flip_fire) && !cln_fire;
		cln_dl_d   = flip_fire ? now + {12'b0, cfg.cleanup_delay_us} : cln_dl_q;

		rel_pend_d = (rel_pend_q || cln_fire) && !rel_fire;
		rel_dl_d   = cln_fire ? now + {12'b0, cfg.release_delay_us} : rel_dl_q;

		midi_pend_d = arm || (midi_pend_q && !midi_fire);
		midi_dl_d   = arm ? now + {12'b0, cfg.midi_delay_us} : midi_dl_q;

		last_press_d = do_press ? now : last_press_q;
	end

	// State registers advance once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engaged_q    <= 1'b0;
			flip_pend_q  <= 1'b0;
			cln_pend_q   <= 1'b0;
			rel_pend_q   <= 1'b0;
			midi_pend_q  <= 1'b0;
			iso_q        <= 1'b1;
			lock_q       <= 1'b0;
			switch_q     <= 1'b0;
			last_press_q <= '0;
			flip_dl_q    <= '0;
			cln_dl_q     <= '0;
			rel_dl_q     <= '0;
			midi_dl_q    <= '0;
		end else if (en) begin
			engaged_q    <= engaged_d;
			flip_pend_q  <= flip_pend_d;
			cln_pend_q   <= cln_pend_d;
			rel_pend_q   <= rel_pend_d;
			midi_pend_q  <= midi_pend_d;
			iso_q        <= iso_d;
			lock_q       <= lock_d;
			switch_q     <= switch_d;
			last_press_q <= last_press_d;
			flip_dl_q    <= flip_dl_d;
			cln_dl_q     <= cln_dl_d;
			rel_dl_q     <= rel_dl_d;
			midi_dl_q    <= midi_dl_d;
		end
	end

	// Pin levels after this item.
	always_comb begin
		result.isolator_level = iso_d;
		result.lock_level     = lock_d;
		result.switch_level   = switch_d;
		result.bypass_led     = engaged_d;
		result.relay_on       = engaged_d;
	end

endmodule

>>> rtl/core/latching_relay_bypass_sequencer_core.sv
// Top level of the latching relay bypass sequencer: input register, step logic, result register.
//
// Usage: send one item per request on in_valid/in_ready/in_data (func and now_us).
// Service items (func 0) run due deadlines, press items (func 1) act as a
// footswitch press, MIDI items (func 2) arm the momentary deadline; code 3
// changes nothing. Every accepted item yields exactly one result item on
// out_valid/out_ready/out_data with the pin levels after that item.
// out_valid rises once the item in the input register has run the state update
// into the result register; a stalled result register holds that update back.
// Throughput is one item per cycle while the receiver keeps out_ready high.
// When the receiver stalls, the result register holds its item and the input
// register keeps the next one; in_ready drops only once both are full.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the register chosen
// by cfg_index; write it only while no item is in flight. Unknown indexes are ignored.
// Reset clears both registers, restores the default delays, leaves the relay
// disengaged with the isolator released and both coils low.
module latching_relay_bypass_sequencer_core
	import lrbs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lrbs_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lrbs_out_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	lrbs_cfg_t cfg;
	lrbs_in_t  item_s1;
	logic      valid_s1;
	lrbs_out_t result;
	lrbs_out_t out_q;
	logic      out_valid_q;
	logic      fire;

	lrbs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The item in the input register is processed when the result slot is free.
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	lrbs_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A new result only appears after an item was processed.
	a_rose_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire))
		else $error("result appeared without a processed item");

	// A waiting item is never dropped from the input register.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1)
		else $error("input register lost an item");

	// The coils are driven complementary or both released.
	a_coils_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.lock_level && out_q.switch_level))
		else $error("both relay coils driven");

	// The LED follows the engaged flag.
	a_led_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.bypass_led == out_q.relay_on))
		else $error("bypass LED differs from engaged flag");

endmodule
